// ===== rtl/core/qwsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwsp_pkg: shared types and constants of the wheel speed pid core
// Item and result payloads, configuration register map, controller commands.
// ----------------------------------------------------------------------------
package qwsp_pkg;

  // field widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int GAIN_W      = 16;
  localparam int SPT_W       = 24;
  localparam int SPEED_W     = 16;
  localparam int DUTY_W      = 8;

  // internal datapath widths
  localparam int ERR_W       = 17;
  localparam int INTEG_W     = 40;
  localparam int INTEG_LO_W  = 20;
  localparam int DELTA_LO_W  = 18;
  localparam int MUL_W       = 25;
  localparam int DERIV_W     = 22;
  localparam int STEP_W      = 15;
  localparam int STEP_SHIFT  = 16;

  // item commands
  localparam logic [1:0] CMD_EDGE_A = 2'd0;
  localparam logic [1:0] CMD_EDGE_B = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPT       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT    = 3'd5;

  // configuration reset values
  localparam logic [GAIN_W-1:0] RST_GAIN_P   = 16'd90;
  localparam logic [GAIN_W-1:0] RST_GAIN_I   = 16'd307;
  localparam logic [GAIN_W-1:0] RST_GAIN_D   = 16'd0;
  localparam logic [GAIN_W-1:0] RST_DEADBAND = 16'd128;
  localparam logic [SPT_W-1:0]  RST_SPT      = 24'd4174;

  // error * 0.1 as error * 6554 / 2^16, rounded
  localparam logic [12:0] STEP_GAIN  = 13'd6554;
  localparam logic [16:0] STEP_ROUND = 17'd32768;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                cmd;
    logic                      level_a;
    logic                      level_b;
    logic signed [SPEED_W-1:0] target_speed;
  } item_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] measured_speed;
    logic [DUTY_W-1:0]         duty;
    logic                      drive_forward;
  } result_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [GAIN_W-1:0] error_deadband;
    logic [SPT_W-1:0]  speed_per_tick;
    logic              invert_direction;
  } cfg_t;

  // multiply-accumulate operations of the shared multiplier
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_SPD_LO = 3'd1,
    OP_SPD_HI = 3'd2,
    OP_STEP   = 3'd3,
    OP_P      = 3'd4,
    OP_I_LO   = 3'd5,
    OP_I_HI   = 3'd6,
    OP_D      = 3'd7
  } mac_op_t;

  typedef struct packed {
    logic    pos_step;
    logic    tick_load;
    mac_op_t op;
    logic    speed_en;
    logic    err_en;
    logic    integ_en;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/qwsp_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwsp_regs: configuration register file
// Gains, deadband, speed scale and direction invert, written by index.
// ----------------------------------------------------------------------------
module qwsp_regs import qwsp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p           <= RST_GAIN_P;
      cfg.gain_i           <= RST_GAIN_I;
      cfg.gain_d           <= RST_GAIN_D;
      cfg.error_deadband   <= RST_DEADBAND;
      cfg.speed_per_tick   <= RST_SPT;
      cfg.invert_direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN_P:   cfg.gain_p           <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:   cfg.gain_i           <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:   cfg.gain_d           <= cfg_data[GAIN_W-1:0];
        CFG_DEADBAND: cfg.error_deadband   <= cfg_data[GAIN_W-1:0];
        CFG_SPT:      cfg.speed_per_tick   <= cfg_data[SPT_W-1:0];
        CFG_INVERT:   cfg.invert_direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/qwsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwsp_ctrl: sequencer of the wheel speed pid core
// Takes items, steps the datapath through one control tick.
// ----------------------------------------------------------------------------
module qwsp_ctrl import qwsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] item_cmd,
  input  sts_t       sts,
  output ctl_t       ctl
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_SPD_LO = 12'b0000_0000_0010,
    S_SPD_HI = 12'b0000_0000_0100,
    S_SPEED  = 12'b0000_0000_1000,
    S_ERR    = 12'b0000_0001_0000,
    S_STEP   = 12'b0000_0010_0000,
    S_INTEG  = 12'b0000_0100_0000,
    S_P      = 12'b0000_1000_0000,
    S_I_LO   = 12'b0001_0000_0000,
    S_I_HI   = 12'b0010_0000_0000,
    S_D      = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          priority if (item_cmd == CMD_EDGE_A || item_cmd == CMD_EDGE_B) begin
            ctl.pos_step = 1'b1;
          end else if (item_cmd == CMD_TICK) begin
            ctl.tick_load = 1'b1;
            state_next    = S_SPD_LO;
          end else begin
            // unused command: taken and dropped
          end
        end
      end
      S_SPD_LO: begin
        ctl.op     = OP_SPD_LO;
        state_next = S_SPD_HI;
      end
      S_SPD_HI: begin
        ctl.op     = OP_SPD_HI;
        state_next = S_SPEED;
      end
      S_SPEED: begin
        ctl.speed_en = 1'b1;
        state_next   = S_ERR;
      end
      S_ERR: begin
        ctl.err_en = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        ctl.op     = OP_STEP;
        state_next = S_INTEG;
      end
      S_INTEG: begin
        ctl.integ_en = 1'b1;
        state_next   = S_P;
      end
      S_P: begin
        ctl.op     = OP_P;
        state_next = S_I_LO;
      end
      S_I_LO: begin
        ctl.op     = OP_I_LO;
        state_next = S_I_HI;
      end
      S_I_HI: begin
        ctl.op     = OP_I_HI;
        state_next = S_D;
      end
      S_D: begin
        ctl.op     = OP_D;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a tick holds off further items while it is worked on
  a_tick_blocks: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_cmd == CMD_TICK) |=> !item_ready)
    else $error("item taken right after a tick");

endmodule

// ===== rtl/core/qwsp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwsp_dp: datapath of the wheel speed pid core
// Quadrature counter, speed scaling, deadband, pid state, shared
// multiply-accumulate unit and the result register.
// ----------------------------------------------------------------------------
module qwsp_dp import qwsp_pkg::*; #(
  parameter int COUNT_WIDTH = 32,
  parameter int FRAC_BITS   = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cfg_t    cfg,
  input  ctl_t    ctl,
  output sts_t    sts,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  // count change is clamped where the speed saturates for any nonzero scale
  localparam int DELTA_W   = 41 - FRAC_BITS;
  localparam int EXT_W     = (COUNT_WIDTH > DELTA_W) ? COUNT_WIDTH : DELTA_W;
  localparam int SPD_SHIFT = 24 - FRAC_BITS;
  localparam int PID_SHIFT = FRAC_BITS + 8;
  localparam int ACC_W     = (65 - FRAC_BITS > 58) ? 65 - FRAC_BITS : 58;

  localparam logic signed [EXT_W-1:0] DELTA_MAX = EXT_W'(1) << (39 - FRAC_BITS);
  localparam logic signed [EXT_W-1:0] DELTA_MIN = -DELTA_MAX;

  logic [COUNT_WIDTH-1:0]     pos_count, pos_count_next, last_pos, cnt_diff;
  logic                       up;
  logic signed [EXT_W-1:0]    d_ext, d_clamp;
  logic signed [DELTA_W-1:0]  delta, delta_next;
  logic signed [SPEED_W-1:0]  target, speed, speed_next;
  logic signed [ERR_W-1:0]    err, err_next, err_raw, prev_err;
  logic [ERR_W-1:0]           err_mag;
  logic signed [INTEG_W-1:0]  integ, integ_next;
  logic signed [INTEG_W:0]    integ_sum;
  logic signed [ERR_W:0]      err_diff;
  logic signed [DERIV_W-1:0]  deriv, deriv_next;
  logic signed [ACC_W-1:0]    acc, acc_next, acc_sh, step_sum, step_full, prod_ext, addend;
  logic signed [STEP_W-1:0]   step;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [2*MUL_W-1:0]  prod;
  logic                       acc_keep, sh_delta, sh_integ, spd_ovf, pid_neg;
  logic [ACC_W-1:0]           pid_abs, pid_mag;
  result_t                    result_next;

  // quadrature counter
  always_comb begin
    up = (item.cmd == CMD_EDGE_A) ? (item.level_a ^ item.level_b)
                                  : !(item.level_a ^ item.level_b);
    pos_count_next = up ? pos_count + COUNT_WIDTH'(1) : pos_count - COUNT_WIDTH'(1);
  end

  // count change since the last tick, two's complement, clamped
  always_comb begin
    cnt_diff = pos_count - last_pos;
    d_ext    = EXT_W'($signed(cnt_diff));
    priority if (d_ext > DELTA_MAX) begin
      d_clamp = DELTA_MAX;
    end else if (d_ext < DELTA_MIN) begin
      d_clamp = DELTA_MIN;
    end else begin
      d_clamp = d_ext;
    end
    delta_next = d_clamp[DELTA_W-1:0];
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    acc_keep = 1'b0;
    sh_delta = 1'b0;
    sh_integ = 1'b0;
    unique case (ctl.op)
      OP_HOLD: ;
      OP_SPD_LO: begin
        mul_a = MUL_W'({1'b0, cfg.speed_per_tick});
        mul_b = MUL_W'({1'b0, delta[DELTA_LO_W-1:0]});
      end
      OP_SPD_HI: begin
        mul_a    = MUL_W'({1'b0, cfg.speed_per_tick});
        mul_b    = MUL_W'($signed(delta[DELTA_W-1:DELTA_LO_W]));
        acc_keep = 1'b1;
        sh_delta = 1'b1;
      end
      OP_STEP: begin
        mul_a = MUL_W'({1'b0, STEP_GAIN});
        mul_b = MUL_W'(err);
      end
      OP_P: begin
        mul_a = MUL_W'({1'b0, cfg.gain_p});
        mul_b = MUL_W'(err);
      end
      OP_I_LO: begin
        mul_a    = MUL_W'({1'b0, cfg.gain_i});
        mul_b    = MUL_W'({1'b0, integ[INTEG_LO_W-1:0]});
        acc_keep = 1'b1;
      end
      OP_I_HI: begin
        mul_a    = MUL_W'({1'b0, cfg.gain_i});
        mul_b    = MUL_W'($signed(integ[INTEG_W-1:INTEG_LO_W]));
        acc_keep = 1'b1;
        sh_integ = 1'b1;
      end
      OP_D: begin
        mul_a    = MUL_W'({1'b0, cfg.gain_d});
        mul_b    = MUL_W'(deriv);
        acc_keep = 1'b1;
      end
    endcase
  end

  always_comb begin
    prod     = mul_a * mul_b;
    prod_ext = ACC_W'(prod);
    if (sh_delta) begin
      addend = prod_ext <<< DELTA_LO_W;
    end else if (sh_integ) begin
      addend = prod_ext <<< INTEG_LO_W;
    end else begin
      addend = prod_ext;
    end
    acc_next = (acc_keep ? acc : '0) + addend;
  end

  // speed: floor shift of the scaled count, saturated to 16 bits
  always_comb begin
    acc_sh  = acc >>> SPD_SHIFT;
    spd_ovf = (acc_sh[ACC_W-1:SPEED_W-1] != {(ACC_W-SPEED_W+1){acc_sh[ACC_W-1]}});
    if (spd_ovf) begin
      speed_next = acc_sh[ACC_W-1] ? SPEED_MIN : SPEED_MAX;
    end else begin
      speed_next = acc_sh[SPEED_W-1:0];
    end
  end

  // error with deadband
  always_comb begin
    err_raw  = ERR_W'(target) - ERR_W'(speed);
    err_mag  = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
    err_next = (err_mag < ERR_W'(cfg.error_deadband)) ? '0 : err_raw;
  end

  // integrator step, saturating integrator, derivative times ten
  always_comb begin
    step_sum  = acc + $signed(ACC_W'(STEP_ROUND));
    step_full = step_sum >>> STEP_SHIFT;
    step      = step_full[STEP_W-1:0];
    integ_sum = (INTEG_W+1)'(integ) + (INTEG_W+1)'(step);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_next = integ_sum[INTEG_W-1:0];
    end
    err_diff   = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err);
    deriv_next = (DERIV_W'(err_diff) <<< 3) + (DERIV_W'(err_diff) <<< 1);
  end

  // duty magnitude and direction from the pid sum
  always_comb begin
    pid_neg = acc[ACC_W-1];
    pid_abs = pid_neg ? ACC_W'(-acc) : ACC_W'(acc);
    pid_mag = pid_abs >> PID_SHIFT;
    result_next.measured_speed = speed;
    result_next.duty = (|pid_mag[ACC_W-1:DUTY_W]) ? {DUTY_W{1'b1}} : pid_mag[DUTY_W-1:0];
    result_next.drive_forward = (!pid_neg || pid_mag == '0) ^ cfg.invert_direction;
  end

  assign sts.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count    <= '0;
      last_pos     <= '0;
      prev_err     <= '0;
      integ        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.pos_step) begin
        pos_count <= pos_count_next;
      end
      if (ctl.tick_load) begin
        last_pos <= pos_count;
      end
      if (ctl.integ_en) begin
        integ    <= integ_next;
        prev_err <= err;
      end
      if (ctl.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tick_load) begin
      delta  <= delta_next;
      target <= item.target_speed;
    end
    if (ctl.op != OP_HOLD) begin
      acc <= acc_next;
    end
    if (ctl.speed_en) begin
      speed <= speed_next;
    end
    if (ctl.err_en) begin
      err <= err_next;
    end
    if (ctl.integ_en) begin
      deriv <= deriv_next;
    end
    if (ctl.out_load) begin
      result <= result_next;
    end
  end

  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(ctl.out_load))
    else $error("result shown without a load");

  a_count_holds: assert property (@(posedge clk) disable iff (rst)
    !$past(ctl.pos_step) |-> $stable(pos_count))
    else $error("position moved without an edge item");

  a_tick_snapshot: assert property (@(posedge clk) disable iff (rst)
    $past(ctl.tick_load) |-> (last_pos == pos_count))
    else $error("tick snapshot differs from position");

endmodule

// ===== rtl/core/quadrature_wheel_speed_pid_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_wheel_speed_pid_core: speed loop for one wheel
// Quadrature position counter plus a per-tick pid speed controller.
// ----------------------------------------------------------------------------
// An encoder edge item (A or B) moves the position count by one and is taken
// in the idle state, so edges may arrive back to back while no tick is being
// worked on. A control tick item carries the speed setpoint; the core turns
// the count change since the previous tick into a Q8.8 speed, forms the error
// with a deadband, updates the integrator and derivative and returns one
// result item with the measured speed, an 8-bit duty and a direction bit. A
// tick runs through the states SPD_LO, SPD_HI, SPEED, ERR, STEP, INTEG, P,
// I_LO, I_HI, D and OUT to the result register, and only then is the next
// item taken (one multiplier is shared by the speed scaling, the integrator
// step and the three pid terms); the next item is taken even while the result
// still waits on result_ready, unless an older result is still pending when
// the new one is done. Edge items give no result, nor does the unused command
// code. Configuration is written through cfg_valid/cfg_index/cfg_data, which
// is always ready; indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module quadrature_wheel_speed_pid_core import qwsp_pkg::*; #(
  parameter int COUNT_WIDTH = 32,
  parameter int FRAC_BITS   = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  // result items
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  ctl_t ctl;
  sts_t sts;

  // register file: gains, deadband, count-to-speed scale, direction invert
  qwsp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: item handshake and tick schedule
  qwsp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_cmd   (item.cmd),
    .sts        (sts),
    .ctl        (ctl)
  );

  // datapath: counter, pid state, shared multiplier, result register
  qwsp_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .ctl          (ctl),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the wheel speed pid core
// Feeds encoder edge and control tick items through a table of directed cases
// and then random bursts under several register settings. Every tick result
// is checked field by field against typed rows or a speed loop predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import qwsp_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 4;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
  localparam int HOLD_CYCLES    = 300;    // long receiver hold-off, once
  localparam int N_PHASES       = 5;
  localparam int PHASE_ITEMS    = 205;
  localparam int MAX_PRINTS     = 40;
  localparam int N_DIRECTED     = 24;

  // command code the core must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // register indexes beyond the map, to be ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  localparam longint SPEED_SHIFT = 24 - 8;  // Q0.24 scale to Q8.8 speed

  typedef struct {
    item_t   it;
    bit      typed;   // expected result typed in below
    result_t res;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state
  cfg_t        m_cfg = '{RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_DEADBAND, RST_SPT, 1'b0};
  logic [31:0] m_pos = '0;
  logic [31:0] m_last_pos = '0;
  longint      m_prev_err = 0;
  longint      m_integ = 0;

  result_t due_results[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      send_steady = 0;
  bit      hold_req = 1'b0;

  // directed cases; only the first ticks from reset are typed in
  row_t directed_rows [N_DIRECTED] = '{
    // no motion, zero setpoint: everything zero, forward
    '{'{CMD_TICK,   1'b0, 1'b0, 16'sd0},      1'b1, '{16'sd0, 8'd0,  1'b1}},
    // largest setpoint
    '{'{CMD_TICK,   1'b0, 1'b0, 16'sh7FFF},   1'b1, '{16'sd0, 8'd60, 1'b1}},
    // most negative setpoint, integrator back to zero
    '{'{CMD_TICK,   1'b0, 1'b0, 16'sh8000},   1'b1, '{16'sd0, 8'd45, 1'b0}},
    // every level pair on both channels, net zero
    '{'{CMD_EDGE_A, 1'b0, 1'b0, 16'sh0000},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_A, 1'b0, 1'b1, 16'shFFFF},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_A, 1'b1, 1'b0, 16'sh0000},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_A, 1'b1, 1'b1, 16'shFFFF},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_B, 1'b0, 1'b0, 16'sh0000},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_B, 1'b0, 1'b1, 16'shFFFF},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_B, 1'b1, 1'b0, 16'sh0000},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_B, 1'b1, 1'b1, 16'shFFFF},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    // unused command, no effect and no result
    '{'{CMD_UNUSED, 1'b1, 1'b1, 16'sh5A5A},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_A, 1'b1, 1'b0, 16'sd0},      1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_A, 1'b0, 1'b1, 16'sd0},      1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_B, 1'b1, 1'b1, 16'sd0},      1'b0, '{16'sd0, 8'd0, 1'b0}},
    // deadband edges on both sides
    '{'{CMD_TICK,   1'b0, 1'b0, 16'sd127},    1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_TICK,   1'b1, 1'b0, 16'sd128},    1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_TICK,   1'b0, 1'b1, 16'shFF80},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_TICK,   1'b1, 1'b1, 16'shFF81},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    // motion backwards
    '{'{CMD_EDGE_A, 1'b1, 1'b1, 16'sd0},      1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_EDGE_B, 1'b0, 1'b1, 16'sd0},      1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_TICK,   1'b0, 1'b0, 16'sd0},      1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_TICK,   1'b0, 1'b0, 16'sh5555},   1'b0, '{16'sd0, 8'd0, 1'b0}},
    '{'{CMD_TICK,   1'b1, 1'b1, 16'shAAAA},   1'b0, '{16'sd0, 8'd0, 1'b0}}
  };

  quadrature_wheel_speed_pid_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one item through the speed loop; returns 1 when a result is due
  function automatic bit speed_loop_step(input item_t it, output result_t res);
    logic [31:0] diff;
    longint      delta, spd, err, abs_err, step, deriv, acc, mag;
    bit          acc_neg;
    res = '0;
    if (it.cmd == CMD_EDGE_A) begin
      // channel A counts up when the levels differ
      m_pos = (it.level_a != it.level_b) ? m_pos + 32'd1 : m_pos - 32'd1;
      return 1'b0;
    end
    if (it.cmd == CMD_EDGE_B) begin
      m_pos = (it.level_a == it.level_b) ? m_pos + 32'd1 : m_pos - 32'd1;
      return 1'b0;
    end
    if (it.cmd != CMD_TICK) return 1'b0;

    // count change since the last tick, read as two's complement
    diff       = m_pos - m_last_pos;
    delta      = longint'($signed(diff));
    m_last_pos = m_pos;

    spd = (delta * longint'(m_cfg.speed_per_tick)) >>> SPEED_SHIFT;
    spd = clamp(spd, longint'(SPEED_MIN), longint'(SPEED_MAX));

    err     = longint'($signed(it.target_speed)) - spd;
    abs_err = (err < 0) ? -err : err;
    if (abs_err < longint'(m_cfg.error_deadband)) err = 0;

    // error * 0.1, rounded with floor
    step    = (err * longint'(STEP_GAIN) + longint'(STEP_ROUND)) >>> STEP_SHIFT;
    m_integ = clamp(m_integ + step, longint'(INTEG_MIN), longint'(INTEG_MAX));

    deriv      = (err - m_prev_err) * 10;
    m_prev_err = err;

    acc = longint'(m_cfg.gain_p) * err + longint'(m_cfg.gain_i) * m_integ
        + longint'(m_cfg.gain_d) * deriv;
    acc_neg = (acc < 0);
    mag     = (acc_neg ? -acc : acc) >>> 16;

    res.measured_speed = spd[SPEED_W-1:0];
    res.duty           = (mag > 255) ? 8'd255 : mag[DUTY_W-1:0];
    // an output that truncates to zero counts as forward
    res.drive_forward  = (!acc_neg || mag == 0) ^ m_cfg.invert_direction;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // offers one item after a random gap and records its expected result
  task automatic push_item(input item_t it, input bit typed, input result_t typed_res);
    int      gap;
    int      r;
    result_t res;
    gap = 0;
    if (send_steady > 0) begin
      send_steady--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) send_steady = $urandom_range(30, 120);
      else if (r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    if (speed_loop_step(it, res)) due_results.push_back(typed ? typed_res : res);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_GAIN_P:   m_cfg.gain_p           = data[GAIN_W-1:0];
      CFG_GAIN_I:   m_cfg.gain_i           = data[GAIN_W-1:0];
      CFG_GAIN_D:   m_cfg.gain_d           = data[GAIN_W-1:0];
      CFG_DEADBAND: m_cfg.error_deadband   = data[GAIN_W-1:0];
      CFG_SPT:      m_cfg.speed_per_tick   = data[SPT_W-1:0];
      CFG_INVERT:   m_cfg.invert_direction = data[0];
      default: ;
    endcase
  endtask

  // stop offering, let all results out, then let a trailing edge item finish
  task automatic settle();
    item_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (due_results.size() == 0) begin
        note_mismatch("result with nothing expected");
      end else begin
        want = due_results.pop_front();
        if (result.measured_speed !== want.measured_speed)
          note_mismatch($sformatf("measured_speed got %0d want %0d",
                                  $signed(result.measured_speed),
                                  $signed(want.measured_speed)));
        if (result.duty !== want.duty)
          note_mismatch($sformatf("duty got %0d want %0d", result.duty, want.duty));
        if (result.drive_forward !== want.drive_forward)
          note_mismatch($sformatf("drive_forward got %b want %b",
                                  result.drive_forward, want.drive_forward));
      end
    end
  end

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int  stall_left;
    int  quiet_left;
    int  r;
    bit  hold_done;
    stall_left = 0;
    quiet_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        // block fills up and must stall its input
        hold_done = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet_left > 0) begin
        quiet_left--;
        result_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          quiet_left = $urandom_range(50, 150);
          result_ready <= 1'b1;
        end else if (r < 65) begin
          result_ready <= 1'b1;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
          result_ready <= 1'b0;
        end
      end
    end
  end

  // no handshake for too long means the core hung
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)
        || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    item_t       it;
    logic [31:0] rnd;
    int          sent;
    int          burst;
    int          r;
    bit          up;
    bit          dir;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset settings
    foreach (directed_rows[i])
      push_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          // top of every range but a zero deadband, unmapped indexes too
          write_reg(CFG_GAIN_P, 24'h00FFFF);
          write_reg(CFG_GAIN_I, 24'h00FFFF);
          write_reg(CFG_GAIN_D, 24'h00FFFF);
          write_reg(CFG_DEADBAND, 24'h000000);
          write_reg(CFG_SPT, 24'hFFFFFF);
          write_reg(CFG_INVERT, 24'h000001);
          write_reg(CFG_UNMAPPED_LO, 24'hFFFFFF);
          write_reg(CFG_UNMAPPED_HI, 24'hFFFFFF);
        end
        1: begin
          // everything zero
          write_reg(CFG_GAIN_P, 24'h000000);
          write_reg(CFG_GAIN_I, 24'h000000);
          write_reg(CFG_GAIN_D, 24'h000000);
          write_reg(CFG_SPT, 24'h000000);
          write_reg(CFG_INVERT, 24'h000000);
        end
        2: begin
          // moderate gains so duty stays mostly below saturation
          write_reg(CFG_GAIN_P, CFG_DATA_W'($urandom_range(0, 4000)));
          write_reg(CFG_GAIN_I, CFG_DATA_W'($urandom_range(0, 4000)));
          write_reg(CFG_GAIN_D, CFG_DATA_W'($urandom_range(0, 2000)));
          write_reg(CFG_DEADBAND, CFG_DATA_W'($urandom_range(0, 600)));
          write_reg(CFG_SPT, CFG_DATA_W'($urandom));
          write_reg(CFG_INVERT, CFG_DATA_W'($urandom));
        end
        3: begin
          // full random data, upper bits on gain writes must be dropped
          write_reg(CFG_GAIN_P, CFG_DATA_W'($urandom));
          write_reg(CFG_GAIN_I, CFG_DATA_W'($urandom));
          write_reg(CFG_GAIN_D, CFG_DATA_W'($urandom));
          write_reg(CFG_DEADBAND, 24'h00FFFF);
          write_reg(CFG_SPT, CFG_DATA_W'($urandom));
          write_reg(CFG_INVERT, CFG_DATA_W'($urandom));
        end
        default: begin
          write_reg(CFG_GAIN_P, CFG_DATA_W'(RST_GAIN_P));
          write_reg(CFG_GAIN_I, CFG_DATA_W'(RST_GAIN_I));
          write_reg(CFG_GAIN_D, CFG_DATA_W'(RST_GAIN_D));
          write_reg(CFG_DEADBAND, CFG_DATA_W'(RST_DEADBAND));
          write_reg(CFG_SPT, RST_SPT);
          write_reg(CFG_INVERT, 24'h000000);
        end
      endcase
      if (ph == 2) hold_req = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          // burst of edges mostly one way, then a tick
          burst = ($urandom_range(0, 99) < 4) ? $urandom_range(100, 200)
                                             : $urandom_range(0, 12);
          if (burst > PHASE_ITEMS - sent) burst = PHASE_ITEMS - sent;
          up = 1'($urandom_range(0, 1));
          for (int k = 0; k < burst; k++) begin
            it.cmd     = $urandom_range(0, 1) ? CMD_EDGE_B : CMD_EDGE_A;
            it.level_a = 1'($urandom_range(0, 1));
            dir        = ($urandom_range(0, 99) < 12) ? ~up : up;
            // a counts up on differing levels, b on equal levels
            it.level_b = (it.cmd == CMD_EDGE_A) ? (it.level_a ^ dir)
                                                : (it.level_a ~^ dir);
            it.target_speed = 16'($urandom);
            push_item(it, 1'b0, '0);
            sent++;
          end
          it.cmd     = CMD_TICK;
          it.level_a = 1'($urandom_range(0, 1));
          it.level_b = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 1)) it.target_speed = 16'($urandom);
          else it.target_speed = 16'($urandom_range(0, 1200) - 600);
          push_item(it, 1'b0, '0);
          sent++;
        end else begin
          // stray item of any kind
          rnd = $urandom;
          it  = rnd[$bits(item_t)-1:0];
          push_item(it, 1'b0, '0);
          sent++;
        end
      end
    end

    settle();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
